/* rtl/core/bfa_pkg.sv */
`timescale 1ns / 1ps

package bfa_pkg;

    // Default geometry. WORD_BITS must be a power of two (frame -> word is a shift).
    localparam int NUM_FRAMES = 65536;
    localparam int WORD_BITS  = 32;

    localparam int FRAME_SHIFT = 12;
    localparam int REQ_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 17;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic [COUNT_W-1:0] USED_RESET  = 17'h10000;

    localparam logic [PADDR_W-3:0] REG_FRAME_LIMIT = 1'b0;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd3;

    typedef struct packed {
        logic               wr;
        logic [COUNT_W-1:0] wr_limit;
        logic [COUNT_W-1:0] limit;
    } cfg_t;

endpackage

/* rtl/core/bfa_ifs.sv */
`timescale 1ns / 1ps

interface bfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::REQ_W-1:0]   req_type;
    logic [bfa_pkg::ADDR_W-1:0]  physical_address;

    modport source (output valid, output req_type, output physical_address, input ready);
    modport sink   (input valid, input req_type, input physical_address, output ready);
endinterface

interface bfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::STATUS_W-1:0]  status;
    logic [bfa_pkg::ADDR_W-1:0]    frame_address;
    logic [bfa_pkg::COUNT_W-1:0]   used_count;

    modport source (output valid, output status, output frame_address, output used_count,
                    input ready);
    modport sink   (input valid, input status, input frame_address, input used_count,
                    output ready);
endinterface

/* rtl/core/bfa_ram.sv */
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int Width = 32,
    parameter int Depth = 2048,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic             re,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/bfa_apb.sv */
`timescale 1ns / 1ps

module bfa_apb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfa_pkg::PDATA_W-1:0]   pwdata,
    output logic [bfa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output bfa_pkg::cfg_t                 cfg
);

    logic [bfa_pkg::COUNT_W-1:0]   limit_reg;
    logic [bfa_pkg::PADDR_W-3:0]   reg_idx;
    logic                          wr_hit;

    assign reg_idx = paddr[bfa_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready
                     && (reg_idx == bfa_pkg::REG_FRAME_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= bfa_pkg::LIMIT_RESET;
        end
        else if (wr_hit)
        begin
            limit_reg <= pwdata[bfa_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = (reg_idx == bfa_pkg::REG_FRAME_LIMIT)
                    ? bfa_pkg::PDATA_W'(limit_reg) : '0;

    assign cfg.wr       = wr_hit;
    assign cfg.wr_limit = pwdata[bfa_pkg::COUNT_W-1:0];
    assign cfg.limit    = limit_reg;

endmodule

/* rtl/core/bfa_engine.sv */
`timescale 1ns / 1ps

module bfa_engine #(
    parameter int NumFrames = bfa_pkg::NUM_FRAMES,
    parameter int WordBits  = bfa_pkg::WORD_BITS,
    localparam int MapWords = (NumFrames + WordBits - 1) / WordBits,
    localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfa_pkg::cfg_t        cfg,
    bfa_req_if.sink              req,
    bfa_rsp_if.source            rsp,
    output logic                 mem_we,
    output logic [AddrW-1:0]     mem_waddr,
    output logic [WordBits-1:0]  mem_wdata,
    output logic                 mem_re,
    output logic [AddrW-1:0]     mem_raddr,
    input  logic [WordBits-1:0]  mem_rdata
);

    localparam int BitW = $clog2(WordBits);
    localparam int IdxW = $clog2(NumFrames + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_SCAN  = 6'b000100,
        S_READ  = 6'b001000,
        S_MOD   = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [AddrW-1:0]                clr_cnt_reg;
    logic [bfa_pkg::COUNT_W-1:0]     used_reg;
    logic [bfa_pkg::COUNT_W-1:0]     used_next;
    logic [IdxW-1:0]                 nf_reg;
    logic [IdxW-1:0]                 start_reg;
    logic [bfa_pkg::REQ_W-1:0]       op_reg;
    logic [AddrW-1:0]                word_reg;
    logic [BitW-1:0]                 bit_reg;
    logic [WordBits-1:0]             wdata_reg;
    logic [bfa_pkg::STATUS_W-1:0]    status_reg;
    logic                            we_pend_reg;
    logic                            inc_reg;
    logic                            dec_reg;
    logic                            nf_upd_reg;
    logic [IdxW-1:0]                 hit_idx_reg;

    // scan read issue side and returning-data tag
    logic [AddrW-1:0]                iss_w_reg;
    logic                            iss_p2_reg;
    logic                            iss_done_reg;
    logic                            d_valid_reg;
    logic [AddrW-1:0]                d_w_reg;
    logic                            d_p2_reg;
    logic                            d_last_reg;

    logic                            out_valid_reg;
    logic [bfa_pkg::STATUS_W-1:0]    out_status_reg;
    logic [bfa_pkg::ADDR_W-1:0]      out_addr_reg;
    logic [bfa_pkg::COUNT_W-1:0]     out_used_reg;

    logic [IdxW-1:0]                 lim;
    logic [IdxW-1:0]                 lim_m1;
    logic [AddrW-1:0]                last_w;
    logic [BitW:0]                   last_hi;
    logic [bfa_pkg::COUNT_W-1:0]     wr_eff;
    logic [IdxW-1:0]                 start_c;
    logic [bfa_pkg::FRAME_W-1:0]     frame;
    logic                            frame_oor;
    logic [AddrW-1:0]                start_w;
    logic [BitW-1:0]                 start_b;
    logic                            iss_last;
    logic [BitW:0]                   lo;
    logic [BitW:0]                   hi;
    logic [WordBits-1:0]             cand;
    logic                            hit;
    logic [BitW-1:0]                 hit_bit;
    logic                            out_free;
    logic                            accept;
    logic                            cur_bit;

    // effective limit saturates at the map size
    assign lim = (32'(cfg.limit) > 32'(NumFrames)) ? IdxW'(NumFrames) : IdxW'(cfg.limit);
    assign wr_eff = (32'(cfg.wr_limit) > 32'(NumFrames))
                    ? bfa_pkg::COUNT_W'(NumFrames) : cfg.wr_limit;
    assign lim_m1  = lim - IdxW'(1);
    assign last_w  = AddrW'(lim_m1 >> BitW);
    assign last_hi = (BitW+1)'(lim_m1[BitW-1:0]) + (BitW+1)'(1);

    assign start_c = (nf_reg < lim) ? nf_reg : lim;
    assign start_w = AddrW'(start_reg >> BitW);
    assign start_b = start_reg[BitW-1:0];

    assign frame     = req.physical_address[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
    assign frame_oor = 32'(frame) >= 32'(lim);

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // phase 1 covers [start, lim), phase 2 wraps over [0, start)
    assign iss_last = iss_p2_reg ? (iss_w_reg == start_w)
                                 : ((iss_w_reg == last_w) && (start_reg == '0));

    always_comb
    begin
        lo = '0;
        hi = (BitW+1)'(WordBits);
        if (!d_p2_reg)
        begin
            if (d_w_reg == start_w)
            begin
                lo = (BitW+1)'(start_b);
            end
            if (d_w_reg == last_w)
            begin
                hi = last_hi;
            end
        end
        else if (d_w_reg == start_w)
        begin
            hi = (BitW+1)'(start_b);
        end
    end

    always_comb
    begin
        for (int b = 0; b < WordBits; b++)
        begin
            cand[b] = !mem_rdata[b] && ((BitW+1)'(b) >= lo) && ((BitW+1)'(b) < hi);
        end
    end

    // lowest free bit wins
    always_comb
    begin
        hit_bit = '0;
        for (int b = WordBits - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                hit_bit = BitW'(b);
            end
        end
    end

    assign hit     = |cand;
    assign cur_bit = mem_rdata[bit_reg];

    always_comb
    begin
        used_next = used_reg;
        if (inc_reg)
        begin
            used_next = used_reg + bfa_pkg::COUNT_W'(1);
        end
        else if (dec_reg && (used_reg != '0))
        begin
            used_next = used_reg - bfa_pkg::COUNT_W'(1);
        end
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = iss_w_reg;
        if ((state_reg == S_SCAN) && !iss_done_reg)
        begin
            mem_re = 1'b1;
        end
        else if (state_reg == S_READ)
        begin
            mem_re    = 1'b1;
            mem_raddr = word_reg;
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '1;
        end
        else
        begin
            mem_we    = (state_reg == S_RESP) && out_free && we_pend_reg;
            mem_waddr = word_reg;
            mem_wdata = wdata_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg.wr)
        begin
            state_next = S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (req.req_type == bfa_pkg::REQ_ALLOC)
                        begin
                            state_next = ((start_c < lim) || (start_c != '0)) ? S_SCAN : S_RESP;
                        end
                        else if ((req.req_type == bfa_pkg::REQ_FREE
                                  || req.req_type == bfa_pkg::REQ_MARK) && !frame_oor)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                end
                S_CLEAR:
                begin
                    if (clr_cnt_reg == AddrW'(MapWords - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (d_valid_reg && (hit || d_last_reg))
                    begin
                        state_next = S_RESP;
                    end
                end
                S_READ:  state_next = S_MOD;
                S_MOD:   state_next = S_RESP;
                S_RESP:
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            used_reg      <= bfa_pkg::USED_RESET;
            nf_reg        <= '0;
            iss_done_reg  <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.wr)
            begin
                clr_cnt_reg <= '0;
                used_reg    <= wr_eff;
                nf_reg      <= '0;
            end
            else
            begin
                if (state_reg == S_CLEAR)
                begin
                    clr_cnt_reg <= clr_cnt_reg + AddrW'(1);
                end
                if (accept)
                begin
                    d_valid_reg  <= 1'b0;
                    iss_done_reg <= 1'b0;
                    iss_p2_reg   <= !(start_c < lim);
                    iss_w_reg    <= (start_c < lim) ? AddrW'(start_c >> BitW) : '0;
                end
                if (state_reg == S_SCAN)
                begin
                    d_valid_reg <= !iss_done_reg;
                    if (!iss_done_reg)
                    begin
                        d_w_reg    <= iss_w_reg;
                        d_p2_reg   <= iss_p2_reg;
                        d_last_reg <= iss_last;
                        if (iss_last)
                        begin
                            iss_done_reg <= 1'b1;
                        end
                        else if (!iss_p2_reg && (iss_w_reg == last_w))
                        begin
                            iss_p2_reg <= 1'b1;
                            iss_w_reg  <= '0;
                        end
                        else
                        begin
                            iss_w_reg <= iss_w_reg + AddrW'(1);
                        end
                    end
                end
                if ((state_reg == S_RESP) && out_free)
                begin
                    used_reg      <= used_next;
                    out_valid_reg <= 1'b1;
                    if (nf_upd_reg)
                    begin
                        nf_reg <= hit_idx_reg;
                    end
                end
            end
        end
    end

    // item payload and decision registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.req_type;
            start_reg   <= start_c;
            word_reg    <= AddrW'(frame >> BitW);
            bit_reg     <= frame[BitW-1:0];
            we_pend_reg <= 1'b0;
            inc_reg     <= 1'b0;
            dec_reg     <= 1'b0;
            nf_upd_reg  <= 1'b0;
            status_reg  <= bfa_pkg::ST_OK;
            if (req.req_type == bfa_pkg::REQ_ALLOC)
            begin
                if (!((start_c < lim) || (start_c != '0)))
                begin
                    status_reg <= bfa_pkg::ST_NO_FREE;
                end
            end
            else if ((req.req_type == bfa_pkg::REQ_FREE || req.req_type == bfa_pkg::REQ_MARK)
                     && frame_oor)
            begin
                status_reg <= bfa_pkg::ST_RANGE;
            end
        end

        if ((state_reg == S_SCAN) && d_valid_reg && !cfg.wr)
        begin
            if (hit)
            begin
                word_reg    <= d_w_reg;
                wdata_reg   <= mem_rdata | (WordBits'(1) << hit_bit);
                we_pend_reg <= 1'b1;
                inc_reg     <= 1'b1;
                nf_upd_reg  <= 1'b1;
                hit_idx_reg <= IdxW'({d_w_reg, hit_bit});
            end
            else if (d_last_reg)
            begin
                status_reg <= bfa_pkg::ST_NO_FREE;
            end
        end

        if (state_reg == S_MOD)
        begin
            if (op_reg == bfa_pkg::REQ_FREE)
            begin
                if (cur_bit)
                begin
                    wdata_reg   <= mem_rdata & ~(WordBits'(1) << bit_reg);
                    we_pend_reg <= 1'b1;
                    dec_reg     <= 1'b1;
                end
                else
                begin
                    status_reg <= bfa_pkg::ST_DOUBLE_FREE;
                end
            end
            else if (!cur_bit)
            begin
                wdata_reg   <= mem_rdata | (WordBits'(1) << bit_reg);
                we_pend_reg <= 1'b1;
                inc_reg     <= 1'b1;
            end
        end

        if ((state_reg == S_RESP) && out_free)
        begin
            out_status_reg <= status_reg;
            out_used_reg   <= used_next;
            out_addr_reg   <= nf_upd_reg
                              ? (bfa_pkg::ADDR_W'(hit_idx_reg) << bfa_pkg::FRAME_SHIFT)
                              : '0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.frame_address = out_addr_reg;
    assign rsp.used_count    = out_used_reg;

endmodule

/* rtl/core/bitmap_frame_allocator.sv */
`timescale 1ns / 1ps

// Bitmap page-frame allocator with next-fit search. One usage bit per 4 KB frame lives in a
// single word-wide synchronous RAM (NumFrames/WordBits words); requests are taken one at a
// time. Free and mark-used go through a read, a modify and a write-back step before the
// result is registered. Allocate scans one bitmap word per cycle from the next-fit pointer
// up to frame_limit and then wraps from frame 0; the RAM read port sets that pace. After
// reset and after every frame_limit write the block sweeps the RAM to all-used, one word
// per cycle, and takes no request until the sweep ends. A frame_limit write also loads
// the used count with the limit, capped at NumFrames; free the usable frames afterwards.
// A result waits in an output register while the next request is accepted. WordBits must
// be a power of two.
module bitmap_frame_allocator #(
    parameter int NumFrames = bfa_pkg::NUM_FRAMES,
    parameter int WordBits  = bfa_pkg::WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bfa_req_if.sink                       req,
    bfa_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfa_pkg::PADDR_W-1:0]   paddr,
    input  logic [bfa_pkg::PDATA_W-1:0]   pwdata,
    output logic [bfa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int MapWords = (NumFrames + WordBits - 1) / WordBits;
    localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;

    bfa_pkg::cfg_t        cfg;
    logic                 mem_we;
    logic [AddrW-1:0]     mem_waddr;
    logic [WordBits-1:0]  mem_wdata;
    logic                 mem_re;
    logic [AddrW-1:0]     mem_raddr;
    logic [WordBits-1:0]  mem_rdata;

    bfa_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfa_engine #(
        .NumFrames (NumFrames),
        .WordBits  (WordBits)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bfa_ram #(
        .Width (WordBits),
        .Depth (MapWords)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* sim/bitmap_frame_allocator_tb.sv */
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 20;

    localparam logic [PADDR_W-3:0] REG_SPARE = 1'b1;
    localparam logic [REQ_W-1:0]   REQ_NONE  = 2'd3;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   frame_address;
        logic [COUNT_W-1:0]  used_count;
    } outcome_t;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        bit                fixed;
        outcome_t          want;
    } step_row_t;

    typedef struct {
        logic [PADDR_W-3:0] reg_idx;
        logic [COUNT_W-1:0] value;
        int                 items;
        bit                 squeeze;
    } phase_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bfa_req_if req_ch();
    bfa_rsp_if rsp_ch();

    bitmap_frame_allocator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the allocator state
    bit                 frame_busy [NUM_FRAMES];
    int unsigned        busy_total;
    int unsigned        search_from;
    logic [COUNT_W-1:0] limit_reg;

    outcome_t pending_outcomes [$];

    int errors       = 0;
    int req_beats    = 0;
    int rsp_beats    = 0;
    int burst_left   = 0;
    int holds_asked  = 0;
    int holds_done   = 0;
    int idle_cycles  = 0;
    int limits_used  = 0;
    bit draining     = 1'b0;
    int status_seen [4] = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned active_frames();
        return (limit_reg > NUM_FRAMES) ? NUM_FRAMES : limit_reg;
    endfunction

    function automatic void reload_map(logic [COUNT_W-1:0] value);
        limit_reg = value;
        foreach (frame_busy[i])
            frame_busy[i] = 1'b1;
        busy_total  = active_frames();
        search_from = 0;
    endfunction

    function automatic outcome_t apply_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr);
        outcome_t    res;
        int unsigned lim;
        int unsigned frame;
        int unsigned start;
        int unsigned f;
        int unsigned i;
        bit          found;
        lim   = active_frames();
        frame = addr >> FRAME_SHIFT;
        res   = '0;
        found = 1'b0;
        f     = 0;
        case (kind)
            REQ_ALLOC:
            begin
                // next fit: from the pointer up to the limit, then wrap from frame 0
                start = (search_from < lim) ? search_from : lim;
                for (i = start; i < lim && !found; i++)
                    if (!frame_busy[i])
                    begin
                        found = 1'b1;
                        f     = i;
                    end
                for (i = 0; i < start && !found; i++)
                    if (!frame_busy[i])
                    begin
                        found = 1'b1;
                        f     = i;
                    end
                if (found)
                begin
                    frame_busy[f]     = 1'b1;
                    busy_total++;
                    search_from       = f;
                    res.frame_address = f << FRAME_SHIFT;
                end
                else
                    res.status = ST_NO_FREE;
            end
            REQ_FREE:
            begin
                if (frame >= lim)
                    res.status = ST_RANGE;
                else if (frame_busy[frame])
                begin
                    frame_busy[frame] = 1'b0;
                    if (busy_total > 0)
                        busy_total--;
                end
                else
                    res.status = ST_DOUBLE_FREE;
            end
            REQ_MARK:
            begin
                if (frame >= lim)
                    res.status = ST_RANGE;
                else if (!frame_busy[frame])
                begin
                    frame_busy[frame] = 1'b1;
                    busy_total++;
                end
            end
            default:
                res.status = ST_OK;
        endcase
        res.used_count = busy_total[COUNT_W-1:0];
        return res;
    endfunction

    function automatic step_row_t step_row(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                           bit fixed, logic [STATUS_W-1:0] status,
                                           logic [ADDR_W-1:0] faddr,
                                           logic [COUNT_W-1:0] used);
        step_row_t r;
        r.kind                = kind;
        r.addr                = addr;
        r.fixed               = fixed;
        r.want.status         = status;
        r.want.frame_address  = faddr;
        r.want.used_count     = used;
        return r;
    endfunction

    function automatic void pick_request(input int unsigned lim, output logic [REQ_W-1:0] kind,
                                         output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        int unsigned sub;
        int unsigned frame;
        roll = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        addr = $urandom;
        if (roll < 38)
            kind = REQ_ALLOC;
        else if (roll < 94)
        begin
            kind = (roll < 78) ? REQ_FREE : REQ_MARK;
            frame = 0;
            if (sub <= 6 && lim > 0)
                frame = $urandom_range(0, lim - 1);
            else if (sub == 7)
                frame = lim;            // first frame past the limit
            else if (sub == 8 && lim > 0)
                frame = lim - 1;        // top managed frame
            if ((sub <= 8) && (sub == 7 || lim > 0))
                addr = (frame << FRAME_SHIFT) | (addr & 32'h0000_0FFF);
        end
        else
            kind = REQ_NONE;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR t=%0t result %0d %s: expected 0x%0h, got 0x%0h",
                     $time, rsp_beats, what, want, got);
    endtask

    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input bit fixed, input outcome_t want);
        outcome_t predicted;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid            <= 1'b1;
        req_ch.req_type         <= kind;
        req_ch.physical_address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(kind, addr);
        pending_outcomes.push_back(fixed ? want : predicted);
        req_beats++;
    endtask

    task automatic apb_access(input logic [PADDR_W-3:0] idx, input bit wr,
                              input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall pattern, plus long holds on request
    initial
    begin
        int mode;
        int left;
        rsp_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (draining)
                rsp_ch.ready <= 1'b1;
            else if (holds_done < holds_asked)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_beats++;
            status_seen[rsp_ch.status]++;
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing pending, status", '0, rsp_ch.status);
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.frame_address !== want.frame_address)
                    report_mismatch("frame_address", want.frame_address, rsp_ch.frame_address);
                if (rsp_ch.used_count !== want.used_count)
                    report_mismatch("used_count", want.used_count, rsp_ch.used_count);
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR t=%0t no progress for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_outcomes.size());
            $display("bitmap_frame_allocator: mismatch");
            $finish;
        end
    end

    initial
    begin
        step_row_t          directed [21];
        phase_t             phases [12];
        logic [REQ_W-1:0]   kind;
        logic [ADDR_W-1:0]  addr;
        logic [PDATA_W-1:0] rd;
        outcome_t           none;

        none = '0;
        rst_n                   <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        req_ch.valid            <= 1'b0;
        req_ch.req_type         <= REQ_ALLOC;
        req_ch.physical_address <= '0;
        reload_map(LIMIT_RESET);

        // after reset every frame is used, limit 65536
        directed = '{
            step_row(REQ_ALLOC, 32'h0000_0000, TYPED, ST_NO_FREE,     32'h0, 17'h10000),
            step_row(REQ_FREE,  32'h0000_0000, TYPED, ST_OK,          32'h0, 17'hFFFF),
            step_row(REQ_FREE,  32'h0000_0FFF, TYPED, ST_DOUBLE_FREE, 32'h0, 17'hFFFF),
            step_row(REQ_ALLOC, 32'hFFFF_FFFF, TYPED, ST_OK,          32'h0, 17'h10000),
            step_row(REQ_FREE,  32'hFFFF_F000, TYPED, ST_RANGE,       32'h0, 17'h10000),
            step_row(REQ_MARK,  32'hFFFF_FFFF, TYPED, ST_RANGE,       32'h0, 17'h10000),
            step_row(REQ_FREE,  32'h1000_0000, TYPED, ST_RANGE,       32'h0, 17'h10000),
            step_row(REQ_FREE,  32'h0FFF_FFFF, TYPED, ST_OK,          32'h0, 17'hFFFF),
            step_row(REQ_ALLOC, 32'h0000_0000, TYPED, ST_OK,  32'h0FFF_F000, 17'h10000),
            step_row(REQ_FREE,  32'h0FFF_F000, TYPED, ST_OK,          32'h0, 17'hFFFF),
            step_row(REQ_MARK,  32'h0FFF_FFFF, TYPED, ST_OK,          32'h0, 17'h10000),
            step_row(REQ_MARK,  32'h0FFF_FABC, TYPED, ST_OK,          32'h0, 17'h10000),
            step_row(REQ_NONE,  32'hFFFF_FFFF, TYPED, ST_OK,          32'h0, 17'h10000),
            step_row(REQ_FREE,  32'h0000_1000, TYPED, ST_OK,          32'h0, 17'hFFFF),
            step_row(REQ_FREE,  32'h0000_5FFF, TYPED, ST_OK,          32'h0, 17'hFFFE),
            // pointer sits at the top frame, so the first of these wraps around
            step_row(REQ_ALLOC, 32'h5555_5555, PREDICTED, ST_OK,      32'h0, 17'h0),
            step_row(REQ_ALLOC, 32'hAAAA_AAAA, PREDICTED, ST_OK,      32'h0, 17'h0),
            step_row(REQ_ALLOC, 32'h0000_0000, TYPED, ST_NO_FREE,     32'h0, 17'h10000),
            step_row(REQ_MARK,  32'h0000_0000, TYPED, ST_OK,          32'h0, 17'h10000),
            step_row(REQ_FREE,  32'h0000_5000, TYPED, ST_OK,          32'h0, 17'hFFFF),
            step_row(REQ_FREE,  32'h0000_5000, TYPED, ST_DOUBLE_FREE, 32'h0, 17'hFFFF)
        };

        phases = '{
            '{REG_FRAME_LIMIT, 17'd1,      30,  1'b0},
            '{REG_FRAME_LIMIT, 17'd0,      20,  1'b0},
            '{REG_FRAME_LIMIT, 17'd32,     150, 1'b0},
            '{REG_FRAME_LIMIT, 17'd33,     130, 1'b1},
            '{REG_FRAME_LIMIT, 17'd64,     150, 1'b0},
            '{REG_SPARE,       17'd17,     60,  1'b0},
            '{REG_FRAME_LIMIT, 17'd100,    180, 1'b0},
            '{REG_FRAME_LIMIT, 17'h1FFFF,  40,  1'b0},
            '{REG_FRAME_LIMIT, 17'd1024,   180, 1'b1},
            '{REG_FRAME_LIMIT, 17'd256,    180, 1'b0},
            '{REG_FRAME_LIMIT, 17'h10000,  30,  1'b0},
            '{REG_FRAME_LIMIT, 17'd200,    120, 1'b0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].kind, directed[i].addr, directed[i].fixed, directed[i].want);
        req_ch.valid <= 1'b0;
        wait_drained();

        foreach (phases[p])
        begin
            apb_access(phases[p].reg_idx, 1'b1, PDATA_W'(phases[p].value), rd);
            if (phases[p].reg_idx == REG_FRAME_LIMIT)
                reload_map(phases[p].value);
            limits_used++;
            // the bus idles between the write and the readback
            @(posedge clk);
            // a write elsewhere must leave the limit register alone
            apb_access(REG_FRAME_LIMIT, 1'b0, '0, rd);
            if (rd !== PDATA_W'(limit_reg))
                report_mismatch("frame_limit readback", PDATA_W'(limit_reg), rd);
            if (phases[p].squeeze)
                holds_asked++;
            for (int n = 0; n < phases[p].items; n++)
            begin
                pick_request(active_frames(), kind, addr);
                send_item(kind, addr, PREDICTED, none);
            end
            req_ch.valid <= 1'b0;
            wait_drained();
        end

        draining = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests through %0d register writes (limits 0 to 65536, saturation).",
                 req_beats, limits_used);
        $display("Results: %0d ok, %0d out of range, %0d double free, %0d no free frame.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_DOUBLE_FREE],
                 status_seen[ST_NO_FREE]);
        if (errors == 0)
            $display("bitmap_frame_allocator: match");
        else
            $display("bitmap_frame_allocator: mismatch");
        $finish;
    end

endmodule
